// ----- src/touch_packet_event_decoder_defines.svh -----
// assertion macros shared by the touch packet event decoder sources
// each macro expects clk and rst to be in scope where it is used
`ifndef TOUCH_PACKET_EVENT_DECODER_DEFINES_SVH
`define TOUCH_PACKET_EVENT_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TPED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TPED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// invariant that holds at every clock edge out of reset
`define TPED_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- src/tped_pkg.sv -----
// shared types, constants and the microcode rom of the touch packet event decoder
// no dependencies
`default_nettype none

package tped_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 14;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int HDR_W      = 6;
  localparam int POS_W      = 3;

  // header decode
  localparam logic [HDR_W-1:0] HDR_MASK = 6'h3f;
  localparam logic [HDR_W-1:0] HDR_DOWN = 6'h11;
  localparam logic [HDR_W-1:0] HDR_UP   = 6'h10;

  // packet byte positions: zero awaits a header
  localparam logic [POS_W-1:0] BYTE_POS_HDR   = 3'd0;
  localparam logic [POS_W-1:0] BYTE_POS_FIRST = 3'd1;
  localparam logic [POS_W-1:0] BYTE_POS_LAST  = 3'd4;

  // scaling divide: size times distance fits in 30 bits
  localparam int PROD_W    = SIZE_W + COORD_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_A     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_B     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_B     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H    = 3'd7;

  // event codes, also the bit positions of the pending-event mask
  typedef enum logic [KIND_W-1:0] {
    EV_PROX_IN  = 3'd0,
    EV_MOTION   = 3'd1,
    EV_PRESS    = 3'd2,
    EV_RELEASE  = 3'd3,
    EV_PROX_OUT = 3'd4
  } event_kind_t;

  localparam int PEND_W = 5;

  // microcode sequencer
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_WAIT    = 4'd0;
  localparam upc_t UPC_MUL_X   = 4'd1;
  localparam upc_t UPC_GO_X    = 4'd2;
  localparam upc_t UPC_DIV_X   = 4'd3;
  localparam upc_t UPC_STORE_X = 4'd4;
  localparam upc_t UPC_MUL_Y   = 4'd5;
  localparam upc_t UPC_GO_Y    = 4'd6;
  localparam upc_t UPC_DIV_Y   = 4'd7;
  localparam upc_t UPC_STORE_Y = 4'd8;
  localparam upc_t UPC_EMIT    = 4'd9;
  localparam upc_t UPC_DONE    = 4'd10;

  // jump conditions: taken jumps load target, otherwise the step counter advances
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_PKT,
    COND_DIV_BUSY,
    COND_EV_PEND
  } cond_t;

  typedef struct packed {
    logic  rx_ready;
    logic  mul_load;
    logic  axis_y;
    logic  div_start;
    logic  store;
    logic  emit;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_word(input upc_t upc);
    ucode_t w;
    w        = '0;
    w.cond   = COND_ALWAYS;
    w.target = UPC_WAIT;
    unique case (upc)
      UPC_WAIT: begin
        w.rx_ready = 1'b1;
        w.cond     = COND_NO_PKT;
        w.target   = UPC_WAIT;
      end
      UPC_MUL_X: begin
        w.mul_load = 1'b1;
        w.cond     = COND_NEVER;
      end
      UPC_GO_X: begin
        w.div_start = 1'b1;
        w.cond      = COND_NEVER;
      end
      UPC_DIV_X: begin
        w.cond   = COND_DIV_BUSY;
        w.target = UPC_DIV_X;
      end
      UPC_STORE_X: begin
        w.store = 1'b1;
        w.cond  = COND_NEVER;
      end
      UPC_MUL_Y: begin
        w.mul_load = 1'b1;
        w.axis_y   = 1'b1;
        w.cond     = COND_NEVER;
      end
      UPC_GO_Y: begin
        w.div_start = 1'b1;
        w.axis_y    = 1'b1;
        w.cond      = COND_NEVER;
      end
      UPC_DIV_Y: begin
        w.axis_y = 1'b1;
        w.cond   = COND_DIV_BUSY;
        w.target = UPC_DIV_Y;
      end
      UPC_STORE_Y: begin
        w.store  = 1'b1;
        w.axis_y = 1'b1;
        w.cond   = COND_NEVER;
      end
      UPC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_EV_PEND;
        w.target = UPC_EMIT;
      end
      UPC_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = UPC_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = UPC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/tped_ifs.sv -----
// valid/ready channels of the touch packet event decoder: received bytes and events
// depends on tped_pkg
`default_nettype none

interface tped_byte_if;
  import tped_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tped_event_if;
  import tped_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic               last;

  modport source (output valid, output event_kind, output pos_x, output pos_y,
                  output last, input ready);
  modport sink (input valid, input event_kind, input pos_x, input pos_y,
                input last, output ready);
endinterface

`default_nettype wire

// ----- src/tped_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on tped_pkg
`default_nettype none

module tped_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [tped_pkg::PROD_W-1:0]    dividend,
  input  wire logic [tped_pkg::COORD_W-1:0]   divisor,
  output      logic                           busy,
  output      logic [tped_pkg::PROD_W-1:0]    quotient
);
  import tped_pkg::*;

  logic [COORD_W-1:0]   den;
  logic [COORD_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COORD_W:0]     trial;
  logic                 fits;
  logic [COORD_W-1:0]   rem_next;

  // trial subtract of the shifted remainder
  always_comb begin
    trial    = {rem, quotient[PROD_W-1]};
    fits     = trial >= {1'b0, den};
    rem_next = fits ? COORD_W'(trial - {1'b0, den}) : trial[COORD_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      den      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[PROD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- src/touch_packet_event_decoder.sv -----
// Touch packet event decoder: frames controller bytes into pen-down and pen-up
// packets and emits proximity, motion and button events with scaled coordinates.
// A byte that does not complete a packet is taken while the sequencer stays in its
// wait step. A complete packet runs the microcode program once, and the input is held
// off until it ends. Most of the program is the bit-serial divide for the calibration
// scaling, once per axis. Up to three events follow, one per cycle while the sink
// is ready. Bytes are not taken while the program runs; the last event may still
// wait in the output register while the next bytes come in. Configuration is
// written through cfg_we/cfg_index/cfg_wdata.
// Depends on tped_pkg, tped_ifs, tped_div and the assertion macro header.
`default_nettype none
`include "touch_packet_event_decoder_defines.svh"

module touch_packet_event_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tped_byte_if.sink                            rx,
  tped_event_if.source                         evt,
  input  wire logic                            cfg_we,
  input  wire logic [tped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tped_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tped_pkg::*;

  // configuration registers
  logic               swap_axes;
  logic               scaled_mode;
  logic [COORD_W-1:0] cal_x_a;
  logic [COORD_W-1:0] cal_x_b;
  logic [COORD_W-1:0] cal_y_a;
  logic [COORD_W-1:0] cal_y_b;
  logic [SIZE_W-1:0]  screen_w;
  logic [SIZE_W-1:0]  screen_h;

  // framing state
  logic [POS_W-1:0]   byte_pos;
  logic [BYTE_W-1:0]  coord_bytes [4];
  logic               in_proximity;
  logic               button_held;
  logic [PEND_W-1:0]  pend_mask;

  // sequencer
  upc_t   upc;
  upc_t   upc_next;
  ucode_t uc;
  logic   take;

  // datapath
  logic [HDR_W-1:0]   hdr;
  logic               rx_xfer;
  logic               pkt_fire;
  logic               pkt_pen;
  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic [COORD_W-1:0] raw_sel;
  logic [COORD_W-1:0] a_sel;
  logic [COORD_W-1:0] b_sel;
  logic [SIZE_W-1:0]  size_sel;
  logic [COORD_W:0]   d_diff;
  logic [COORD_W:0]   d_inv;
  logic [COORD_W:0]   s_diff;
  logic [COORD_W:0]   s_inv;
  logic [COORD_W-1:0] d_mag;
  logic [COORD_W-1:0] s_mag;
  logic [PROD_W-1:0]  prod_comb;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] span_mag;
  logic               span_zero;
  logic               quo_neg;
  logic               div_busy;
  logic [PROD_W-1:0]  div_quo;
  logic [SIZE_W-1:0]  scaled_v;
  logic [COORD_W-1:0] axis_res;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;

  // event output register
  logic               ev_valid;
  event_kind_t        ev_kind;
  logic [COORD_W-1:0] ev_x;
  logic [COORD_W-1:0] ev_y;
  logic               ev_last;
  logic               ev_load;
  event_kind_t        next_kind;
  logic [PEND_W-1:0]  pend_rest;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_axes   <= 1'b0;
      scaled_mode <= 1'b1;
      cal_x_a     <= 16'd0;
      cal_x_b     <= 16'd1024;
      cal_y_a     <= 16'd768;
      cal_y_b     <= 16'd0;
      screen_w    <= 14'd1024;
      screen_h    <= 14'd768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWAP_AXES:   swap_axes   <= cfg_wdata[0];
        REG_SCALED_MODE: scaled_mode <= cfg_wdata[0];
        REG_CAL_X_A:     cal_x_a     <= cfg_wdata;
        REG_CAL_X_B:     cal_x_b     <= cfg_wdata;
        REG_CAL_Y_A:     cal_y_a     <= cfg_wdata;
        REG_CAL_Y_B:     cal_y_b     <= cfg_wdata;
        REG_SCREEN_W:    screen_w    <= cfg_wdata[SIZE_W-1:0];
        REG_SCREEN_H:    screen_h    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // control word of the current step
  assign uc = ucode_word(upc);

  // step counter with conditional jumps
  always_comb begin
    case (uc.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_PKT:   take = !pkt_fire;
      COND_DIV_BUSY: take = div_busy;
      COND_EV_PEND:  take = pend_mask != '0;
      default:       take = 1'b0;
    endcase
    upc_next = take ? uc.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  // byte framing
  assign rx.ready = uc.rx_ready;
  assign rx_xfer  = rx.valid && rx.ready;
  assign hdr      = rx.rx_byte[HDR_W-1:0] & HDR_MASK;
  assign pkt_pen  = byte_pos == BYTE_POS_LAST;
  assign pkt_fire = rx_xfer && (pkt_pen || (byte_pos == BYTE_POS_HDR && hdr == HDR_UP));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= BYTE_POS_HDR;
      for (int i = 0; i < 4; i++) begin
        coord_bytes[i] <= '0;
      end
    end else if (rx_xfer) begin
      if (byte_pos != BYTE_POS_HDR) begin
        coord_bytes[2'(byte_pos - BYTE_POS_FIRST)] <= rx.rx_byte;
        byte_pos <= pkt_pen ? BYTE_POS_HDR : byte_pos + 1'b1;
      end else if (hdr == HDR_DOWN) begin
        byte_pos <= BYTE_POS_FIRST;
      end
    end
  end

  // pen state and the events that a packet owes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_proximity <= 1'b0;
      button_held  <= 1'b0;
      pend_mask    <= '0;
    end else if (pkt_fire) begin
      pend_mask[EV_PROX_IN]  <= !in_proximity && pkt_pen;
      pend_mask[EV_MOTION]   <= 1'b1;
      pend_mask[EV_PRESS]    <= !button_held && pkt_pen;
      pend_mask[EV_RELEASE]  <= button_held && !pkt_pen;
      pend_mask[EV_PROX_OUT] <= in_proximity && !pkt_pen;
      in_proximity           <= pkt_pen;
      button_held            <= pkt_pen;
    end else if (ev_load) begin
      pend_mask <= pend_rest;
    end
  end

  // axis operand selection
  always_comb begin
    raw_x    = swap_axes ? {coord_bytes[2], coord_bytes[3]} : {coord_bytes[0], coord_bytes[1]};
    raw_y    = swap_axes ? {coord_bytes[0], coord_bytes[1]} : {coord_bytes[2], coord_bytes[3]};
    raw_sel  = uc.axis_y ? raw_y : raw_x;
    a_sel    = uc.axis_y ? cal_y_a : cal_x_a;
    b_sel    = uc.axis_y ? cal_y_b : cal_x_b;
    size_sel = uc.axis_y ? screen_h : screen_w;
  end

  // signed distance and span as sign and magnitude, then size times distance
  always_comb begin
    d_diff    = {1'b0, raw_sel} - {1'b0, b_sel};
    d_inv     = ~d_diff + 1'b1;
    d_mag     = d_diff[COORD_W] ? d_inv[COORD_W-1:0] : d_diff[COORD_W-1:0];
    s_diff    = {1'b0, a_sel} - {1'b0, b_sel};
    s_inv     = ~s_diff + 1'b1;
    s_mag     = s_diff[COORD_W] ? s_inv[COORD_W-1:0] : s_diff[COORD_W-1:0];
    prod_comb = {{(PROD_W-SIZE_W){1'b0}}, size_sel} * {{(PROD_W-COORD_W){1'b0}}, d_mag};
  end

  always_ff @(posedge clk) begin
    if (uc.mul_load) begin
      prod      <= prod_comb;
      span_mag  <= s_mag;
      span_zero <= s_diff == '0;
      quo_neg   <= d_diff[COORD_W] ^ s_diff[COORD_W];
    end
  end

  tped_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uc.div_start),
    .dividend (prod),
    .divisor  (span_mag),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // size minus the truncated quotient, clamped to the screen; zero when the span is empty
  always_comb begin
    if (span_zero) begin
      scaled_v = '0;
    end else if (quo_neg) begin
      scaled_v = size_sel;
    end else if (div_quo >= {{(PROD_W-SIZE_W){1'b0}}, size_sel}) begin
      scaled_v = '0;
    end else begin
      scaled_v = size_sel - div_quo[SIZE_W-1:0];
    end
    axis_res = scaled_mode ? {{(COORD_W-SIZE_W){1'b0}}, scaled_v} : raw_sel;
  end

  always_ff @(posedge clk) begin
    if (uc.store) begin
      if (uc.axis_y) begin
        res_y <= axis_res;
      end else begin
        res_x <= axis_res;
      end
    end
  end

  // lowest pending event goes next
  always_comb begin
    if (pend_mask[EV_PROX_IN]) begin
      next_kind = EV_PROX_IN;
    end else if (pend_mask[EV_MOTION]) begin
      next_kind = EV_MOTION;
    end else if (pend_mask[EV_PRESS]) begin
      next_kind = EV_PRESS;
    end else if (pend_mask[EV_RELEASE]) begin
      next_kind = EV_RELEASE;
    end else begin
      next_kind = EV_PROX_OUT;
    end
    pend_rest = pend_mask & (pend_mask - 1'b1);
    ev_load   = uc.emit && pend_mask != '0 && (!ev_valid || evt.ready);
  end

  // event output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ev_load) begin
      ev_valid <= 1'b1;
    end else if (evt.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_load) begin
      ev_kind <= next_kind;
      ev_x    <= res_x;
      ev_y    <= res_y;
      ev_last <= pend_rest == '0;
    end
  end

  assign evt.valid      = ev_valid;
  assign evt.event_kind = ev_kind;
  assign evt.pos_x      = ev_x;
  assign evt.pos_y      = ev_y;
  assign evt.last       = ev_last;

  // checks
  `TPED_ASSERT_SAME(a_div_start_idle, uc.div_start, !div_busy, "divider started while busy")
  `TPED_ASSERT_ALWAYS(a_button_in_prox, !button_held || in_proximity, "button held out of proximity")
  `TPED_ASSERT_SAME(a_rx_after_events, rx_xfer, pend_mask == '0, "byte taken with events pending")
  `TPED_ASSERT_NEXT(a_store_after_div, uc.store, $past(!div_busy), "result stored before divide ended")

endmodule

`default_nettype wire

// ----- tb/touch_packet_event_decoder_tb.sv -----
`timescale 1ns / 1ps
// testbench of the touch packet event decoder: a directed table, then random packet traffic
// over several register settings, every event checked against the table or a predictor
// depends on tped_pkg, tped_ifs and touch_packet_event_decoder

module touch_packet_event_decoder_tb;
  import tped_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int MAX_GAP      = 11;
  localparam int MAX_EVENTS   = 3;
  localparam int NUM_REGS     = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 225;
  localparam int PHASE_ITEMS  = 40;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    event_kind_t        kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } touch_event_t;

  typedef enum logic {ROW_RX, ROW_CFG} row_op_t;

  // one line of the directed table: a byte or a register write, with optional typed events
  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    logic [1:0]            n_events;
    event_kind_t [0:2]     kinds;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tped_byte_if  rx_ch ();
  tped_event_if evt_ch ();

  touch_packet_event_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .evt       (evt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // predictor copy of the settings
  logic               set_swap;
  logic               set_scaled;
  logic [COORD_W-1:0] cal_xa, cal_xb, cal_ya, cal_yb;
  logic [SIZE_W-1:0]  disp_w, disp_h;

  // predictor copy of the framer state
  logic [POS_W-1:0]   pkt_pos;
  logic [BYTE_W-1:0]  coord_byte [4];
  logic               pen_near;
  logic               pen_pressed;

  touch_event_t packet_events [MAX_EVENTS];
  touch_event_t pending_events [$];
  stim_row_t    directed_rows [$];

  logic sender_no_gaps;
  logic sink_no_stalls;
  logic sink_hold_req;

  int cycle_count;
  int mismatches;
  int bytes_sent;
  int random_items;
  int bad_headers;
  int events_seen;
  int packets_seen;
  int hold_offs;
  int phases_run;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // linear map of one raw axis onto the screen, rounding toward zero, then clamped
  function automatic logic [COORD_W-1:0] scale_coord(input logic [COORD_W-1:0] raw,
                                                     input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b,
                                                     input logic [SIZE_W-1:0] size);
    longint r, la, lb, ls, v;
    r  = raw;
    la = a;
    lb = b;
    ls = size;
    if (la == lb) return '0;
    v = (-ls * (r - lb)) / (la - lb) + ls;
    if (v < 0) v = 0;
    if (v > ls) v = ls;
    return v[COORD_W-1:0];
  endfunction

  // frame one byte; fills packet_events and returns how many events it causes
  function automatic int decode_rx_byte(input logic [BYTE_W-1:0] b);
    logic               stylus_down;
    logic [COORD_W-1:0] x, y, t;
    int                 n;
    n = 0;
    if (pkt_pos >= BYTE_POS_FIRST && pkt_pos <= BYTE_POS_LAST) begin
      coord_byte[pkt_pos - BYTE_POS_FIRST] = b;
      if (pkt_pos != BYTE_POS_LAST) begin
        pkt_pos = pkt_pos + 1'b1;
        return 0;
      end
      pkt_pos     = BYTE_POS_HDR;
      stylus_down = 1'b1;
    end else begin
      pkt_pos = BYTE_POS_HDR;
      if ((b[HDR_W-1:0] & HDR_MASK) == HDR_DOWN) begin
        pkt_pos = BYTE_POS_FIRST;
        return 0;
      end
      if ((b[HDR_W-1:0] & HDR_MASK) != HDR_UP) return 0;
      stylus_down = 1'b0;
    end

    // coordinates, swapped before scaling
    x = {coord_byte[0], coord_byte[1]};
    y = {coord_byte[2], coord_byte[3]};
    if (set_swap) begin
      t = x;
      x = y;
      y = t;
    end
    if (set_scaled) begin
      x = scale_coord(x, cal_xa, cal_xb, disp_w);
      y = scale_coord(y, cal_ya, cal_yb, disp_h);
    end

    // events in driver order
    if (!pen_near && stylus_down) begin
      pen_near = 1'b1;
      packet_events[n] = '{EV_PROX_IN, x, y, 1'b0};
      n = n + 1;
    end
    packet_events[n] = '{EV_MOTION, x, y, 1'b0};
    n = n + 1;
    if (!pen_pressed && stylus_down) begin
      pen_pressed = 1'b1;
      packet_events[n] = '{EV_PRESS, x, y, 1'b0};
      n = n + 1;
    end else if (pen_pressed && !stylus_down) begin
      pen_pressed = 1'b0;
      packet_events[n] = '{EV_RELEASE, x, y, 1'b0};
      n = n + 1;
    end
    if (pen_near && !stylus_down && n < MAX_EVENTS) begin
      pen_near = 1'b0;
      packet_events[n] = '{EV_PROX_OUT, x, y, 1'b0};
      n = n + 1;
    end
    packet_events[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic stim_row_t row_rx(input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r       = '0;
    r.op    = ROW_RX;
    r.value = CFG_DATA_W'(b);
    return r;
  endfunction

  function automatic stim_row_t row_quiet(input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r       = row_rx(b);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row_ev(input logic [BYTE_W-1:0] b, input logic [1:0] n,
                                      input event_kind_t k0, input event_kind_t k1,
                                      input event_kind_t k2, input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
    stim_row_t r;
    r          = row_quiet(b);
    r.n_events = n;
    r.kinds[0] = k0;
    r.kinds[1] = k1;
    r.kinds[2] = k2;
    r.x        = x;
    r.y        = y;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r           = '0;
    r.op        = ROW_CFG;
    r.reg_index = idx;
    r.value     = val;
    return r;
  endfunction

  // register write on the falling edge, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SWAP_AXES:   set_swap   = val[0];
      REG_SCALED_MODE: set_scaled = val[0];
      REG_CAL_X_A:     cal_xa     = val;
      REG_CAL_X_B:     cal_xb     = val;
      REG_CAL_Y_A:     cal_ya     = val;
      REG_CAL_Y_B:     cal_yb     = val;
      REG_SCREEN_W:    disp_w     = val[SIZE_W-1:0];
      REG_SCREEN_H:    disp_h     = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // drop valid, let every event come back, then give a packet in flight time to finish
  task automatic wait_idle();
    rx_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // offer one byte after a random gap; on transfer, queue what it should cause
  task automatic send_rx_byte(input stim_row_t row);
    int gap;
    int n;
    int i;
    gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = row.value[BYTE_W-1:0];
    do @(posedge clk); while (!rx_ch.ready);
    n = decode_rx_byte(row.value[BYTE_W-1:0]);
    if (row.typed) begin
      for (i = 0; i < int'(row.n_events); i++)
        pending_events.push_back('{row.kinds[i], row.x, row.y, i == int'(row.n_events) - 1});
    end else begin
      for (i = 0; i < n; i++) pending_events.push_back(packet_events[i]);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // raw coordinate: extremes, calibration ends, inside the window, or anything
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return a + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      3: return b + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      4: return lo + COORD_W'($urandom_range(0, hi - lo));
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // settings of one random phase; every register is written each time
  task automatic load_phase_settings(input int phase);
    logic [CFG_DATA_W-1:0] v [NUM_REGS];
    int i;
    for (i = 0; i < NUM_REGS; i++) v[i] = CFG_DATA_W'($urandom());
    v[REG_SWAP_AXES]   = CFG_DATA_W'($urandom_range(0, 1));
    v[REG_SCALED_MODE] = CFG_DATA_W'(1'b1);
    v[REG_SCREEN_W]    = CFG_DATA_W'($urandom_range(1, SIZE_MAX));
    v[REG_SCREEN_H]    = CFG_DATA_W'($urandom_range(1, SIZE_MAX));
    case (phase % 5)
      0: begin
        // full-scale mapping onto the largest screen
        v[REG_CAL_X_A]  = '0;
        v[REG_CAL_X_B]  = '1;
        v[REG_CAL_Y_A]  = '1;
        v[REG_CAL_Y_B]  = '0;
        v[REG_SCREEN_W] = CFG_DATA_W'(SIZE_MAX);
        v[REG_SCREEN_H] = CFG_DATA_W'(SIZE_MAX);
      end
      1: begin
        // narrow windows on a one-pixel screen
        v[REG_CAL_X_B]  = v[REG_CAL_X_A] + CFG_DATA_W'($urandom_range(1, 8));
        v[REG_CAL_Y_A]  = v[REG_CAL_Y_B] + CFG_DATA_W'($urandom_range(1, 8));
        v[REG_SCREEN_W] = CFG_DATA_W'(1);
        v[REG_SCREEN_H] = CFG_DATA_W'(1);
      end
      2: begin
        // raw coordinates, swapped
        v[REG_SCALED_MODE] = '0;
        v[REG_SWAP_AXES]   = CFG_DATA_W'(1'b1);
      end
      3: begin
        // empty range on x, zero-size screen on y
        v[REG_CAL_X_B]  = v[REG_CAL_X_A];
        v[REG_SCREEN_H] = '0;
      end
      default: ;
    endcase
    for (i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), v[i]);
    phases_run++;
  endtask

  // one random packet: mostly well formed, some dropped headers and cut-off packets
  task automatic send_random_packet(output int counted);
    logic [BYTE_W-1:0]  burst [$];
    logic [BYTE_W-1:0]  b;
    logic [COORD_W-1:0] x, y;
    int                 pick;
    int                 i;
    pick = $urandom_range(0, 99);
    x    = set_swap ? pick_coord(cal_ya, cal_yb) : pick_coord(cal_xa, cal_xb);
    y    = set_swap ? pick_coord(cal_xa, cal_xb) : pick_coord(cal_ya, cal_yb);
    burst.delete();
    counted = 0;
    if (pick < 55) begin
      burst = '{{2'($urandom()), HDR_DOWN}, x[15:8], x[7:0], y[15:8], y[7:0]};
    end else if (pick < 80) begin
      burst.push_back({2'($urandom()), HDR_UP});
    end else if (pick < 90) begin
      b = BYTE_W'($urandom());
      while ((b[HDR_W-1:0] & HDR_MASK) == HDR_DOWN || (b[HDR_W-1:0] & HDR_MASK) == HDR_UP)
        b = BYTE_W'($urandom());
      burst.push_back(b);
      bad_headers++;
    end else begin
      // cut-off pen-down: the following header is taken as a coordinate byte
      burst.push_back({2'($urandom()), HDR_DOWN});
      for (i = $urandom_range(0, 3); i > 0; i--) burst.push_back(BYTE_W'($urandom()));
    end
    if (pick < 80 || pick >= 90) counted = burst.size();
    foreach (burst[k]) send_rx_byte(row_rx(burst[k]));
  endtask

  // event receiver: random stalls, plus one long hold-off on request
  initial begin : event_sink
    int stall;
    evt_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        evt_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
        hold_offs++;
      end
      stall = sink_no_stalls ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        evt_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      evt_ch.ready = 1'b1;
      do @(posedge clk); while (!evt_ch.valid);
      @(negedge clk);
    end
  end

  // compare each event transfer with the oldest expected one
  always @(posedge clk) begin : event_check
    touch_event_t want;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event, kind", 32'(evt_ch.event_kind), '0);
      end else begin
        want = pending_events.pop_front();
        events_seen++;
        if (want.last) packets_seen++;
        if (evt_ch.event_kind != want.kind)
          report_mismatch("event_kind", 32'(evt_ch.event_kind), 32'(want.kind));
        if (evt_ch.pos_x != want.x) report_mismatch("pos_x", 32'(evt_ch.pos_x), 32'(want.x));
        if (evt_ch.pos_y != want.y) report_mismatch("pos_y", 32'(evt_ch.pos_y), 32'(want.y));
        if (evt_ch.last != want.last)
          report_mismatch("last", 32'(evt_ch.last), 32'(want.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached, %0d events outstanding", cycle_count,
               pending_events.size());
      $display("touch_packet_event_decoder test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int counted;
    int phase_items;

    // inputs known from the start, predictor at its reset state
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SWAP_AXES;
    cfg_wdata      = '0;
    sender_no_gaps = 1'b0;
    sink_no_stalls = 1'b0;
    sink_hold_req  = 1'b0;
    set_swap       = 1'b0;
    set_scaled     = 1'b1;
    cal_xa         = 16'd0;
    cal_xb         = 16'd1024;
    cal_ya         = 16'd768;
    cal_yb         = 16'd0;
    disp_w         = 14'd1024;
    disp_h         = 14'd768;
    pkt_pos        = BYTE_POS_HDR;
    coord_byte     = '{default: '0};
    pen_near       = 1'b0;
    pen_pressed    = 1'b0;

    // directed table
    directed_rows = '{
      // pen-up straight after reset: zero coordinates through the reset calibration
      row_ev({2'b00, HDR_UP}, 2'd1, EV_MOTION, EV_MOTION, EV_MOTION, 16'd0, 16'd768),
      // headers that are neither pen-down nor pen-up
      row_quiet(8'hff),
      row_quiet(8'h3f),
      // raw mode, pen-down with top header bits set and extreme coordinates
      row_cfg(REG_SCALED_MODE, 16'd0),
      row_quiet({2'b11, HDR_DOWN}),
      row_quiet(8'hff),
      row_quiet(8'hff),
      row_quiet(8'h00),
      row_ev(8'h00, 2'd3, EV_PROX_IN, EV_MOTION, EV_PRESS, 16'hffff, 16'h0000),
      // pen held: motion only
      row_quiet({2'b01, HDR_DOWN}),
      row_quiet(8'h00),
      row_quiet(8'h00),
      row_quiet(8'hff),
      row_ev(8'hff, 2'd1, EV_MOTION, EV_MOTION, EV_MOTION, 16'h0000, 16'hffff),
      // pen-up reuses the last coordinates, then a second pen-up
      row_ev({2'b10, HDR_UP}, 2'd3, EV_MOTION, EV_RELEASE, EV_PROX_OUT, 16'h0000, 16'hffff),
      row_ev({2'b00, HDR_UP}, 2'd1, EV_MOTION, EV_MOTION, EV_MOTION, 16'h0000, 16'hffff),
      // swapped axes
      row_cfg(REG_SWAP_AXES, 16'd1),
      row_quiet({2'b00, HDR_DOWN}),
      row_quiet(8'h12),
      row_quiet(8'h34),
      row_quiet(8'h56),
      row_ev(8'h78, 2'd3, EV_PROX_IN, EV_MOTION, EV_PRESS, 16'h5678, 16'h1234),
      // scaled again: empty x range, zero screen height
      row_cfg(REG_SWAP_AXES, 16'd0),
      row_cfg(REG_SCALED_MODE, 16'd1),
      row_cfg(REG_CAL_X_A, 16'd100),
      row_cfg(REG_CAL_X_B, 16'd100),
      row_cfg(REG_SCREEN_H, 16'd0),
      row_quiet({2'b00, HDR_DOWN}),
      row_quiet(8'h01),
      row_quiet(8'h00),
      row_quiet(8'h02),
      row_ev(8'h00, 2'd1, EV_MOTION, EV_MOTION, EV_MOTION, 16'd0, 16'd0),
      row_rx({2'b00, HDR_UP})
    };

    // release reset on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].value);
      end else begin
        send_rx_byte(directed_rows[i]);
      end
    end

    // random phases, each opened once every event has come back
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      load_phase_settings(phase);
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      sink_no_stalls = ($urandom_range(0, 3) == 0);
      if (phase == 1) sink_hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        send_random_packet(counted);
        phase_items  += counted;
        random_items += counted;
      end
      phase++;
    end

    // drain
    rx_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d random, %0d dropped headers) under %0d register settings",
             bytes_sent, random_items, bad_headers, phases_run);
    $display("checked %0d events from %0d packets, %0d long receiver hold-off(s), %0d errors",
             events_seen, packets_seen, hold_offs, mismatches);
    if (mismatches == 0) begin
      $display("touch_packet_event_decoder test passed");
    end else begin
      $display("touch_packet_event_decoder test failed");
    end
    $finish;
  end

endmodule
